FILE: rtl/core/sst_pkg.sv
// Package for the session token table: widths, codes and shared types.
package sst_pkg;

  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned EXP_W       = 33;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned TOKEN_W     = 4 * WORD_W;
  localparam int unsigned SLOT_IDX_W  = 3;
  localparam int unsigned COUNT_W     = 4;
  localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd86400;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_VALIDATE   = 2'd1,
    OP_LOGOUT     = 2'd2,
    OP_LOGOUT_ALL = 2'd3
  } sst_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } sst_state_e;

  typedef struct packed {
    logic expired;
    logic below;
    logic match;
  } sst_cmp_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  evicted;
    logic [COUNT_W-1:0]    live_count;
    logic [COUNT_W-1:0]    cleared_count;
  } sst_result_t;

endpackage

FILE: rtl/core/sst_in_if.sv
// Request channel: opcode, current time and 256-bit token.
interface sst_in_if import sst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [TIME_W-1:0]   now;
  logic [WORD_W-1:0]   token_word0;
  logic [WORD_W-1:0]   token_word1;
  logic [WORD_W-1:0]   token_word2;
  logic [WORD_W-1:0]   token_word3;

  modport source (
    output valid, opcode, now, token_word0, token_word1, token_word2, token_word3,
    input  ready
  );
  modport sink (
    input  valid, opcode, now, token_word0, token_word1, token_word2, token_word3,
    output ready
  );
endinterface

FILE: rtl/core/sst_out_if.sv
// Result channel of the session token table.
interface sst_out_if import sst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic                  evicted;
  logic [COUNT_W-1:0]    live_count;
  logic [COUNT_W-1:0]    cleared_count;

  modport source (
    output valid, hit, slot_index, evicted, live_count, cleared_count,
    input  ready
  );
  modport sink (
    input  valid, hit, slot_index, evicted, live_count, cleared_count,
    output ready
  );
endinterface

FILE: rtl/core/sst_cfg_if.sv
// Configuration write channel carrying the session lifetime.
interface sst_cfg_if import sst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/session_token_table_top.sv
// Top level of the session token table.
// Each request is handled by walking the slots one per cycle through a single compare unit
// (expiry check, lowest-expiry compare and 256-bit token match) fed by the token memory's
// registered read port. A request is captured in the idle state, then the scan state walks
// every slot for insert and logout-all (followed by the write state for insert) and stops
// early for validate and logout when a match is found; the done state then holds the
// result until it is transferred. The block takes no new request until the result is
// transferred. Active flags clear at reset; the lifetime register resets to 86400 seconds and
// may be written while no request is in flight.
module session_token_table_top import sst_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sst_in_if.sink     in_i,
  sst_out_if.source  out_o,
  sst_cfg_if.sink    cfg_i
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);

  logic [TIME_W-1:0]  lifetime_q;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [IW-1:0]      mem_raddr;
  logic [TOKEN_W-1:0] token;
  logic [TOKEN_W-1:0] row;
  logic [TIME_W-1:0]  now;
  logic [EXP_W-1:0]   expiry;
  logic [EXP_W-1:0]   min_expiry;
  sst_cmp_t           cmp;
  sst_result_t        result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= LIFETIME_RESET;
    end else if (cfg_i.valid) begin
      lifetime_q <= cfg_i.data;
    end
  end

  sst_token_mem #(
    .DEPTH (SLOT_COUNT)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (token),
    .raddr_i (mem_raddr),
    .rdata_o (row)
  );

  sst_cmp u_cmp (
    .now_i        (now),
    .expiry_i     (expiry),
    .min_expiry_i (min_expiry),
    .row_i        (row),
    .token_i      (token),
    .res_o        (cmp)
  );

  sst_seq #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_op_i      (sst_op_e'(in_i.opcode)),
    .in_now_i     (in_i.now),
    .in_token_i   ({in_i.token_word3, in_i.token_word2, in_i.token_word1, in_i.token_word0}),
    .lifetime_i   (lifetime_q),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .result_o     (result),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .token_o      (token),
    .mem_raddr_o  (mem_raddr),
    .now_o        (now),
    .expiry_o     (expiry),
    .min_expiry_o (min_expiry),
    .cmp_i        (cmp)
  );

  assign out_o.hit           = result.hit;
  assign out_o.slot_index    = result.slot_index;
  assign out_o.evicted       = result.evicted;
  assign out_o.live_count    = result.live_count;
  assign out_o.cleared_count = result.cleared_count;

endmodule

FILE: rtl/core/sst_token_mem.sv
// Token memory: one 256-bit row per slot, one write and one registered read port.
module sst_token_mem import sst_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [TOKEN_W-1:0] wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [TOKEN_W-1:0] rdata_o
);

  logic [TOKEN_W-1:0] mem [DEPTH];
  logic [TOKEN_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sst_cmp.sv
// Shared compare unit: expiry check, minimum-expiry compare and token match.
module sst_cmp import sst_pkg::*; (
  input  logic [TIME_W-1:0]  now_i,
  input  logic [EXP_W-1:0]   expiry_i,
  input  logic [EXP_W-1:0]   min_expiry_i,
  input  logic [TOKEN_W-1:0] row_i,
  input  logic [TOKEN_W-1:0] token_i,
  output sst_cmp_t           res_o
);

  assign res_o.expired = {1'b0, now_i} > expiry_i;
  assign res_o.below   = expiry_i < min_expiry_i;
  assign res_o.match   = row_i == token_i;

endmodule

FILE: rtl/core/sst_seq.sv
// Slot scan sequencer: active flags, expiry registers, counters and result register.
module sst_seq import sst_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8,
  localparam int unsigned IW        = $clog2(SLOT_COUNT),
  localparam int unsigned CW        = $clog2(SLOT_COUNT + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sst_op_e            in_op_i,
  input  logic [TIME_W-1:0]  in_now_i,
  input  logic [TOKEN_W-1:0] in_token_i,
  input  logic [TIME_W-1:0]  lifetime_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sst_result_t        result_o,
  output logic               mem_we_o,
  output logic [IW-1:0]      mem_waddr_o,
  output logic [TOKEN_W-1:0] token_o,
  output logic [IW-1:0]      mem_raddr_o,
  output logic [TIME_W-1:0]  now_o,
  output logic [EXP_W-1:0]   expiry_o,
  output logic [EXP_W-1:0]   min_expiry_o,
  input  sst_cmp_t           cmp_i
);

  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

  sst_state_e state_q, state_d;

  sst_op_e            op_q, op_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TOKEN_W-1:0] tok_q, tok_d;

  logic [SLOT_COUNT-1:0] act_q, act_d;
  logic [EXP_W-1:0]      exp_q [SLOT_COUNT];
  logic                  exp_we;

  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_run_q, rd_run_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] ev_idx_q, ev_idx_d;

  logic             found_q, found_d;
  logic [EXP_W-1:0] min_q, min_d;
  logic [IW-1:0]    min_idx_q, min_idx_d;
  logic [CW-1:0]    act_cnt_q, act_cnt_d;
  logic [CW-1:0]    clr_q, clr_d;
  logic             hit_q, hit_d;
  logic [IW-1:0]    slot_q, slot_d;
  logic             evict_q, evict_d;

  logic          ev_act;
  logic          ev_last;
  logic          ev_stale;
  logic [IW-1:0] wslot;

  assign ev_act   = act_q[ev_idx_q];
  assign ev_last  = ev_idx_q == LAST;
  assign ev_stale = ev_act && cmp_i.expired;
  assign wslot    = found_q ? slot_q : min_idx_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_q) begin
          priority if (op_q == OP_VALIDATE && ev_act && !cmp_i.expired && cmp_i.match) begin
            state_d = ST_DONE;
          end else if (op_q == OP_LOGOUT && ev_act && cmp_i.match) begin
            state_d = ST_DONE;
          end else if (ev_last) begin
            state_d = (op_q == OP_INSERT) ? ST_WRITE : ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_WRITE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = state_q == ST_IDLE;
    out_valid_o = state_q == ST_DONE;
    mem_we_o    = state_q == ST_WRITE;
    exp_we      = state_q == ST_WRITE;
  end

  // datapath
  always_comb begin
    op_d      = op_q;
    now_d     = now_q;
    tok_d     = tok_q;
    act_d     = act_q;
    rd_idx_d  = rd_idx_q;
    rd_run_d  = rd_run_q;
    pend_d    = pend_q;
    ev_idx_d  = ev_idx_q;
    found_d   = found_q;
    min_d     = min_q;
    min_idx_d = min_idx_q;
    act_cnt_d = act_cnt_q;
    clr_d     = clr_q;
    hit_d     = hit_q;
    slot_d    = slot_q;
    evict_d   = evict_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_op_i;
          now_d    = in_now_i;
          tok_d    = in_token_i;
          rd_idx_d = '0;
          rd_run_d = 1'b1;
          pend_d   = 1'b0;
          found_d  = 1'b0;
          clr_d    = '0;
          hit_d    = 1'b0;
          slot_d   = '0;
          evict_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        pend_d   = rd_run_q;
        ev_idx_d = rd_idx_q;
        if (rd_run_q) begin
          if (rd_idx_q == LAST) begin
            rd_run_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (pend_q) begin
          unique case (op_q)
            OP_INSERT: begin
              if (ev_stale) begin
                act_d[ev_idx_q] = 1'b0;
                clr_d           = clr_q + 1'b1;
                act_cnt_d       = act_cnt_q - 1'b1;
              end
              if ((!ev_act || cmp_i.expired) && !found_q) begin
                found_d = 1'b1;
                slot_d  = ev_idx_q;
              end
              if (ev_idx_q == '0 || cmp_i.below) begin
                min_d     = expiry_o;
                min_idx_d = ev_idx_q;
              end
            end
            OP_VALIDATE: begin
              if (ev_stale) begin
                act_d[ev_idx_q] = 1'b0;
                clr_d           = clr_q + 1'b1;
                act_cnt_d       = act_cnt_q - 1'b1;
              end else if (ev_act && cmp_i.match) begin
                hit_d  = 1'b1;
                slot_d = ev_idx_q;
              end
            end
            OP_LOGOUT: begin
              if (ev_act && cmp_i.match) begin
                act_d[ev_idx_q] = 1'b0;
                clr_d           = clr_q + 1'b1;
                act_cnt_d       = act_cnt_q - 1'b1;
                hit_d           = 1'b1;
                slot_d          = ev_idx_q;
              end
            end
            OP_LOGOUT_ALL: begin
              if (ev_act) begin
                act_d[ev_idx_q] = 1'b0;
                clr_d           = clr_q + 1'b1;
                act_cnt_d       = act_cnt_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        act_d[wslot] = 1'b1;
        slot_d       = wslot;
        if (found_q) begin
          act_cnt_d = act_cnt_q + 1'b1;
        end else begin
          evict_d = 1'b1;
          clr_d   = clr_q + 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      act_q     <= '0;
      act_cnt_q <= '0;
      rd_run_q  <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      act_cnt_q <= act_cnt_d;
      rd_run_q  <= rd_run_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    now_q     <= now_d;
    tok_q     <= tok_d;
    rd_idx_q  <= rd_idx_d;
    ev_idx_q  <= ev_idx_d;
    found_q   <= found_d;
    min_q     <= min_d;
    min_idx_q <= min_idx_d;
    clr_q     <= clr_d;
    hit_q     <= hit_d;
    slot_q    <= slot_d;
    evict_q   <= evict_d;
    if (exp_we) begin
      exp_q[wslot] <= {1'b0, now_q} + {1'b0, lifetime_i};
    end
  end

  assign mem_waddr_o  = wslot;
  assign token_o      = tok_q;
  assign mem_raddr_o  = rd_idx_q;
  assign now_o        = now_q;
  assign expiry_o     = exp_q[ev_idx_q];
  assign min_expiry_o = min_q;

  assign result_o.hit           = hit_q;
  assign result_o.slot_index    = SLOT_IDX_W'(slot_q);
  assign result_o.evicted       = evict_q;
  assign result_o.live_count    = COUNT_W'(act_cnt_q);
  assign result_o.cleared_count = COUNT_W'(clr_q);

endmodule
